FILE: design/buddy_block_allocator_assert.svh
// Assertion macros for the buddy block allocator checker.
`ifndef BUDDY_BLOCK_ALLOCATOR_ASSERT_SVH
`define BUDDY_BLOCK_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BBA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("buddy allocator check failed");

// Next-cycle implication, disabled during reset.
`define BBA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("buddy allocator check failed");

`endif

FILE: design/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Types and constants shared by the buddy block allocator files.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int LEVEL_SLOTS_DEF = 11;
  localparam int BUCKET_W        = 17;
  localparam int REQ_W           = 27;
  localparam int ADDR_W          = 32;
  localparam int LEVEL_W         = 4;
  localparam int NODE_BITS_DEF   = LEVEL_SLOTS_DEF;

  localparam logic [ADDR_W-1:0]   HDR_BYTES       = 32'd8;
  localparam logic [LEVEL_W-1:0]  LEVEL_COUNT_RST = 4'd10;
  localparam logic [BUCKET_W-1:0] BUCKET_RST      = 17'd64;
  localparam logic [ADDR_W-1:0]   BASE_RST        = 32'd0;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [1:0] {
    CFG_LEVEL_COUNT,
    CFG_BUCKET_BYTES,
    CFG_POOL_BASE
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_ABSENT,
    ST_FREE,
    ST_ALLOC,
    ST_SPLIT
  } node_st_t;

  typedef enum logic [1:0] {
    RS_OK,
    RS_NO_BLOCK,
    RS_NOT_ALLOC
  } res_st_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_A_CHK,
    S_A_LVL,
    S_A_FIND,
    S_A_SPL,
    S_A_SPR,
    S_A_SPP,
    S_A_ADR1,
    S_A_ADR2,
    S_F_SCAN,
    S_F_MB,
    S_F_MC,
    S_F_MD,
    S_F_ME,
    S_F_MF,
    S_D_RD,
    S_D_P,
    S_D_PW,
    S_D_Q,
    S_D_QW,
    S_D_N,
    S_U_W,
    S_U_R,
    S_U_M,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              cmd;
    logic [REQ_W-1:0]  request_bytes;
    logic [ADDR_W-1:0] release_address;
  } bba_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [ADDR_W-1:0]  granted_address;
    logic [LEVEL_W-1:0] granted_level;
  } bba_out_t;

endpackage

FILE: design/bba_node_ram.sv
// ----------------------------------------------------------------------------
// bba_node_ram
// Single-port node table RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module bba_node_ram
  import bba_pkg::*;
#(
  parameter int ADDR_BITS = NODE_BITS_DEF,
  parameter int DATA_BITS = 2 + 2 * NODE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] addr,
  input  logic [DATA_BITS-1:0] wdata,
  output logic [DATA_BITS-1:0] rdata
);

  logic [DATA_BITS-1:0] mem [1 << ADDR_BITS];
  logic [DATA_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/buddy_block_allocator.sv
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Buddy allocator over a heap-numbered block tree; node table in one RAM.
// ----------------------------------------------------------------------------
//  channel | ports                          | transfer
//  input   | start, busy, in_item           | start high while busy low
//  result  | out_strobe, out_item           | one cycle, strobe high
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | valid and ready high
//
// One item at a time through a sequencer over the node RAM, one access a cycle.
// Allocate: choose a level, search the free lists, split down to that level, then
// take the block and form its address. Free: a table scan at one node a cycle,
// then relink the block and merge it with each free buddy before answering.
// After reset and after a level_count write a clearing pass over every node entry
// holds busy high. The result receiver cannot stall.
module buddy_block_allocator
  import bba_pkg::*;
#(
  parameter int MAX_LEVEL_SLOTS = LEVEL_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  bba_in_t     in_item,
  output logic        out_strobe,
  output bba_out_t    out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int NW  = MAX_LEVEL_SLOTS;
  localparam int LVW = $clog2(MAX_LEVEL_SLOTS);
  localparam int MW  = BUCKET_W + MAX_LEVEL_SLOTS - 1;
  localparam int SW  = REQ_W + 1;
  localparam int CW  = (SW > MW) ? SW : MW;
  localparam int JW  = MAX_LEVEL_SLOTS - 1;
  localparam int PW  = JW + BUCKET_W;
  localparam int EW  = 2 + 2 * NW;

  typedef struct packed {
    node_st_t        st;
    logic [NW-1:0]   nxt;
    logic [NW-1:0]   prv;
  } ent_t;

  state_t               state_r, state_nxt, ret_r, ret_nxt;
  logic [NW-1:0]        clr_r, clr_nxt;
  logic [NW-1:0]        head_r [MAX_LEVEL_SLOTS];
  logic [NW-1:0]        head_nxt [MAX_LEVEL_SLOTS];
  logic [NW-1:0]        tail_r [MAX_LEVEL_SLOTS];
  logic [NW-1:0]        tail_nxt [MAX_LEVEL_SLOTS];
  logic [LEVEL_W-1:0]   lcount_r, lcount_nxt;
  logic [BUCKET_W-1:0]  bucket_r, bucket_nxt;
  logic [ADDR_W-1:0]    base_r, base_nxt;

  logic [SW-1:0]        s_r, s_nxt;
  logic [MW-1:0]        sh_r, sh_nxt;
  logic [LVW-1:0]       k_r, k_nxt;
  logic [LVW-1:0]       hl_r, hl_nxt;
  logic [NW-1:0]        n_r, n_nxt;
  logic [NW-1:0]        dn_r, dn_nxt;
  logic [NW-1:0]        pn_r, pn_nxt;
  logic                 pf_r, pf_nxt;
  logic [NW-1:0]        nb_r, nb_nxt;
  logic [NW-1:0]        p_r, p_nxt;
  logic [NW-1:0]        q_r, q_nxt;
  node_st_t             st_r, st_nxt;
  logic [ADDR_W-1:0]    tgt_r, tgt_nxt;
  logic [NW:0]          sn_r, sn_nxt;
  logic [LVW-1:0]       slv_r, slv_nxt;
  logic [ADDR_W-1:0]    saddr_r, saddr_nxt;
  logic [MW-1:0]        step_r, step_nxt;
  logic                 pv_r, pv_nxt;
  logic [NW-1:0]        pnode_r, pnode_nxt;
  logic [ADDR_W-1:0]    paddr_r, paddr_nxt;
  logic [LVW-1:0]       plv_r, plv_nxt;
  logic [PW-1:0]        prod_r, prod_nxt;
  bba_out_t             res_r, res_nxt;

  logic                 mem_en, mem_we;
  logic [NW-1:0]        mem_addr;
  ent_t                 wr_ent, rd_ent;
  logic [EW-1:0]        mem_rd;

  logic                 cfg_wr, cfg_lc_wr;
  logic [LVW-1:0]       lv_use;
  logic [MW-1:0]        mem_bytes;
  logic [NW:0]          limit_w;
  logic                 size_over, lvl_step, scan_issue, scan_hit, new_level;
  logic [NW-1:0]        hd_w, tl_w, nb_w, idx_w;
  logic [JW-1:0]        j_w;

  bba_node_ram #(
    .ADDR_BITS (NW),
    .DATA_BITS (EW)
  ) u_ram (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (wr_ent),
    .rdata (mem_rd)
  );

  assign rd_ent     = ent_t'(mem_rd);
  assign cfg_ready  = 1'b1;
  assign cfg_wr     = cfg_valid && cfg_ready;
  assign cfg_lc_wr  = cfg_wr && (cfg_index == CFG_LEVEL_COUNT);
  assign busy       = (state_r != S_IDLE);
  assign out_strobe = (state_r == S_DONE);
  assign out_item   = res_r;

  assign lv_use     = (int'(lcount_r) < MAX_LEVEL_SLOTS - 1) ? LVW'(lcount_r)
                                                             : LVW'(MAX_LEVEL_SLOTS - 1);
  assign mem_bytes  = MW'(bucket_r) << lv_use;
  assign limit_w    = (NW+1)'(2) << lv_use;
  assign size_over  = CW'(s_r) > CW'(mem_bytes);
  assign lvl_step   = (k_r < lv_use) && (((MW+1)'(sh_r) << 1) <= (MW+1)'(mem_bytes));
  assign scan_issue = (sn_r != limit_w);
  assign scan_hit   = pv_r && (rd_ent.st == ST_ALLOC) && (paddr_r == tgt_r);
  assign new_level  = (((sn_r + 1'b1) & sn_r) == '0);
  assign hd_w       = head_r[hl_r];
  assign tl_w       = tail_r[hl_r];
  assign nb_w       = pf_r ? hd_w : tl_w;
  assign idx_w      = n_r ^ (NW'(1) << k_r);
  assign j_w        = JW'(idx_w) << (lv_use - k_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:  if (clr_r == '1) state_nxt = S_IDLE;
      S_IDLE: begin
        if (start) begin
          state_nxt = (in_item.cmd == CMD_FREE) ? S_F_SCAN : S_A_CHK;
        end
      end
      S_A_CHK:  state_nxt = size_over ? S_DONE : S_A_LVL;
      S_A_LVL:  if (!lvl_step) state_nxt = S_A_FIND;
      S_A_FIND: begin
        if (hd_w != '0) begin
          state_nxt = S_D_RD;
        end else if (hl_r == '0) begin
          state_nxt = S_DONE;
        end
      end
      S_A_SPL:  state_nxt = (hl_r < k_r) ? S_U_W : S_A_ADR1;
      S_A_SPR:  state_nxt = S_U_W;
      S_A_SPP:  state_nxt = S_D_RD;
      S_A_ADR1: state_nxt = S_A_ADR2;
      S_A_ADR2: state_nxt = S_DONE;
      S_F_SCAN: begin
        if (scan_hit) begin
          state_nxt = S_U_W;
        end else if (!scan_issue && !pv_r) begin
          state_nxt = S_DONE;
        end
      end
      S_F_MB:   state_nxt = (n_r == NW'(1)) ? S_DONE : S_F_MC;
      S_F_MC:   state_nxt = (rd_ent.st != ST_FREE) ? S_DONE : S_D_RD;
      S_F_MD:   state_nxt = S_D_RD;
      S_F_ME:   state_nxt = S_F_MF;
      S_F_MF:   state_nxt = S_U_W;
      S_D_RD:   state_nxt = S_D_P;
      S_D_P:    state_nxt = (rd_ent.prv != '0) ? S_D_PW : S_D_Q;
      S_D_PW:   state_nxt = S_D_Q;
      S_D_Q:    state_nxt = (q_r != '0) ? S_D_QW : S_D_N;
      S_D_QW:   state_nxt = S_D_N;
      S_D_N:    state_nxt = ret_r;
      S_U_W:    state_nxt = (nb_w == '0) ? ret_r : S_U_R;
      S_U_R:    state_nxt = S_U_M;
      S_U_M:    state_nxt = ret_r;
      S_DONE:   state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
    if (cfg_lc_wr) state_nxt = S_CLEAR;
  end

  always_comb begin
    ret_nxt    = ret_r;
    clr_nxt    = clr_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    lcount_nxt = lcount_r;
    bucket_nxt = bucket_r;
    base_nxt   = base_r;
    s_nxt      = s_r;
    sh_nxt     = sh_r;
    k_nxt      = k_r;
    hl_nxt     = hl_r;
    n_nxt      = n_r;
    dn_nxt     = dn_r;
    pn_nxt     = pn_r;
    pf_nxt     = pf_r;
    nb_nxt     = nb_r;
    p_nxt      = p_r;
    q_nxt      = q_r;
    st_nxt     = st_r;
    tgt_nxt    = tgt_r;
    sn_nxt     = sn_r;
    slv_nxt    = slv_r;
    saddr_nxt  = saddr_r;
    step_nxt   = step_r;
    pv_nxt     = pv_r;
    pnode_nxt  = pnode_r;
    paddr_nxt  = paddr_r;
    plv_nxt    = plv_r;
    prod_nxt   = prod_r;
    res_nxt    = res_r;
    mem_en     = 1'b0;
    mem_we     = 1'b0;
    mem_addr   = n_r;
    wr_ent     = '0;

    unique case (state_r)
      S_CLEAR: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = clr_r;
        wr_ent.st = (clr_r == NW'(1)) ? ST_FREE : ST_ABSENT;
        clr_nxt   = clr_r + 1'b1;
      end
      S_IDLE: begin
        if (start) begin
          s_nxt     = SW'(in_item.request_bytes) + SW'(HDR_BYTES);
          tgt_nxt   = in_item.release_address;
          sn_nxt    = (NW+1)'(1);
          slv_nxt   = '0;
          saddr_nxt = base_r + HDR_BYTES;
          step_nxt  = mem_bytes;
          pv_nxt    = 1'b0;
        end
      end
      S_A_CHK: begin
        if (size_over) begin
          res_nxt.status          = RS_NO_BLOCK;
          res_nxt.granted_address = '0;
          res_nxt.granted_level   = '0;
        end else begin
          k_nxt  = '0;
          sh_nxt = MW'(s_r);
        end
      end
      S_A_LVL: begin
        if (lvl_step) begin
          k_nxt  = k_r + 1'b1;
          sh_nxt = sh_r << 1;
        end else begin
          hl_nxt = k_r;
        end
      end
      S_A_FIND: begin
        if (hd_w != '0) begin
          n_nxt   = hd_w;
          dn_nxt  = hd_w;
          ret_nxt = S_A_SPL;
        end else if (hl_r != '0) begin
          hl_nxt = hl_r - 1'b1;
        end else begin
          res_nxt.status          = RS_NO_BLOCK;
          res_nxt.granted_address = '0;
          res_nxt.granted_level   = '0;
        end
      end
      S_A_SPL: begin
        mem_en   = 1'b1;
        mem_we   = 1'b1;
        mem_addr = n_r;
        if (hl_r < k_r) begin
          wr_ent.st = ST_SPLIT;
          hl_nxt    = hl_r + 1'b1;
          pn_nxt    = n_r << 1;
          pf_nxt    = 1'b0;
          ret_nxt   = S_A_SPR;
        end else begin
          wr_ent.st = ST_ALLOC;
        end
      end
      S_A_SPR: begin
        pn_nxt  = (n_r << 1) | NW'(1);
        ret_nxt = S_A_SPP;
      end
      S_A_SPP: begin
        n_nxt   = hd_w;
        dn_nxt  = hd_w;
        ret_nxt = S_A_SPL;
      end
      S_A_ADR1: begin
        prod_nxt = PW'(j_w) * PW'(bucket_r);
      end
      S_A_ADR2: begin
        res_nxt.status          = RS_OK;
        res_nxt.granted_address = base_r + ADDR_W'(prod_r) + HDR_BYTES;
        res_nxt.granted_level   = LEVEL_W'(k_r);
      end
      S_F_SCAN: begin
        if (scan_hit) begin
          res_nxt.status          = RS_OK;
          res_nxt.granted_address = '0;
          res_nxt.granted_level   = LEVEL_W'(plv_r);
          hl_nxt                  = plv_r;
          n_nxt                   = pnode_r;
          pn_nxt                  = pnode_r;
          pf_nxt                  = 1'b1;
          ret_nxt                 = S_F_MB;
        end else if (scan_issue) begin
          mem_en    = 1'b1;
          mem_addr  = sn_r[NW-1:0];
          pv_nxt    = 1'b1;
          pnode_nxt = sn_r[NW-1:0];
          paddr_nxt = saddr_r;
          plv_nxt   = slv_r;
          sn_nxt    = sn_r + 1'b1;
          if (new_level) begin
            slv_nxt   = slv_r + 1'b1;
            saddr_nxt = base_r + HDR_BYTES;
            step_nxt  = step_r >> 1;
          end else begin
            saddr_nxt = saddr_r + ADDR_W'(step_r);
          end
        end else begin
          pv_nxt = 1'b0;
          if (!pv_r) begin
            res_nxt.status          = RS_NOT_ALLOC;
            res_nxt.granted_address = '0;
            res_nxt.granted_level   = '0;
          end
        end
      end
      S_F_MB: begin
        if (n_r != NW'(1)) begin
          mem_en   = 1'b1;
          mem_addr = n_r ^ NW'(1);
        end
      end
      S_F_MC: begin
        dn_nxt  = n_r;
        ret_nxt = S_F_MD;
      end
      S_F_MD: begin
        dn_nxt  = n_r ^ NW'(1);
        ret_nxt = S_F_ME;
      end
      S_F_ME: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = n_r;
        wr_ent.st = ST_ABSENT;
      end
      S_F_MF: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = n_r ^ NW'(1);
        wr_ent.st = ST_ABSENT;
        n_nxt     = n_r >> 1;
        pn_nxt    = n_r >> 1;
        hl_nxt    = hl_r - 1'b1;
        pf_nxt    = 1'b1;
        ret_nxt   = S_F_MB;
      end
      S_D_RD: begin
        mem_en   = 1'b1;
        mem_addr = dn_r;
      end
      S_D_P: begin
        p_nxt  = rd_ent.prv;
        q_nxt  = rd_ent.nxt;
        st_nxt = rd_ent.st;
        if (rd_ent.prv != '0) begin
          mem_en   = 1'b1;
          mem_addr = rd_ent.prv;
        end else begin
          head_nxt[hl_r] = rd_ent.nxt;
        end
      end
      S_D_PW: begin
        mem_en     = 1'b1;
        mem_we     = 1'b1;
        mem_addr   = p_r;
        wr_ent     = rd_ent;
        wr_ent.nxt = q_r;
      end
      S_D_Q: begin
        if (q_r != '0) begin
          mem_en   = 1'b1;
          mem_addr = q_r;
        end else begin
          tail_nxt[hl_r] = p_r;
        end
      end
      S_D_QW: begin
        mem_en     = 1'b1;
        mem_we     = 1'b1;
        mem_addr   = q_r;
        wr_ent     = rd_ent;
        wr_ent.prv = p_r;
      end
      S_D_N: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = dn_r;
        wr_ent.st = st_r;
      end
      S_U_W: begin
        mem_en     = 1'b1;
        mem_we     = 1'b1;
        mem_addr   = pn_r;
        wr_ent.st  = ST_FREE;
        wr_ent.nxt = pf_r ? hd_w : '0;
        wr_ent.prv = pf_r ? '0 : tl_w;
        nb_nxt     = nb_w;
        if (nb_w == '0) begin
          head_nxt[hl_r] = pn_r;
          tail_nxt[hl_r] = pn_r;
        end
      end
      S_U_R: begin
        mem_en   = 1'b1;
        mem_addr = nb_r;
      end
      S_U_M: begin
        mem_en   = 1'b1;
        mem_we   = 1'b1;
        mem_addr = nb_r;
        wr_ent   = rd_ent;
        if (pf_r) begin
          wr_ent.prv     = pn_r;
          head_nxt[hl_r] = pn_r;
        end else begin
          wr_ent.nxt     = pn_r;
          tail_nxt[hl_r] = pn_r;
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase

    if (cfg_wr) begin
      unique case (cfg_index)
        CFG_LEVEL_COUNT: begin
          lcount_nxt = cfg_data[LEVEL_W-1:0];
          clr_nxt    = '0;
          for (int i = 0; i < MAX_LEVEL_SLOTS; i++) begin
            head_nxt[i] = (i == 0) ? NW'(1) : '0;
            tail_nxt[i] = (i == 0) ? NW'(1) : '0;
          end
        end
        CFG_BUCKET_BYTES: bucket_nxt = cfg_data[BUCKET_W-1:0];
        CFG_POOL_BASE:    base_nxt   = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      ret_r    <= S_IDLE;
      clr_r    <= '0;
      lcount_r <= LEVEL_COUNT_RST;
      bucket_r <= BUCKET_RST;
      base_r   <= BASE_RST;
      for (int i = 0; i < MAX_LEVEL_SLOTS; i++) begin
        head_r[i] <= (i == 0) ? NW'(1) : '0;
        tail_r[i] <= (i == 0) ? NW'(1) : '0;
      end
    end else begin
      state_r  <= state_nxt;
      ret_r    <= ret_nxt;
      clr_r    <= clr_nxt;
      lcount_r <= lcount_nxt;
      bucket_r <= bucket_nxt;
      base_r   <= base_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r     <= s_nxt;
    sh_r    <= sh_nxt;
    k_r     <= k_nxt;
    hl_r    <= hl_nxt;
    n_r     <= n_nxt;
    dn_r    <= dn_nxt;
    pn_r    <= pn_nxt;
    pf_r    <= pf_nxt;
    nb_r    <= nb_nxt;
    p_r     <= p_nxt;
    q_r     <= q_nxt;
    st_r    <= st_nxt;
    tgt_r   <= tgt_nxt;
    sn_r    <= sn_nxt;
    slv_r   <= slv_nxt;
    saddr_r <= saddr_nxt;
    step_r  <= step_nxt;
    pv_r    <= pv_nxt;
    pnode_r <= pnode_nxt;
    paddr_r <= paddr_nxt;
    plv_r   <= plv_nxt;
    prod_r  <= prod_nxt;
    res_r   <= res_nxt;
  end

endmodule

FILE: design/bba_checker.sv
// ----------------------------------------------------------------------------
// bba_checker
// Port-level checks for the buddy block allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "buddy_block_allocator_assert.svh"

module bba_checker
  import bba_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     out_strobe,
  input bba_out_t out_item
);

  `BBA_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `BBA_ASSERT_NEXT(a_strobe_single, out_strobe, !out_strobe)
  `BBA_ASSERT_NOW(a_strobe_busy, out_strobe, busy)
  `BBA_ASSERT_NOW(a_status_code, out_strobe, out_item.status <= RS_NOT_ALLOC)
  `BBA_ASSERT_NOW(a_fail_zero, out_strobe && (out_item.status != RS_OK),
                  {out_item.granted_address, out_item.granted_level} == '0)

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_item   (out_item)
);
